>>> src/pbrq_pkg.sv
// ----------------------------------------------------------------------------
// pbrq_pkg
// Types and constants shared by the per-bank request queue block.
// ----------------------------------------------------------------------------
package pbrq_pkg;

    // default sizing
    localparam int BANKS_DEF       = 16;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int ROW_BITS_DEF    = 16;

    // action codes
    localparam logic [1:0] ACT_STORE  = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    // spare code, handled as a query
    localparam logic [1:0] ACT_SPARE  = 2'd3;

    // configuration register file
    localparam int          APB_ADDR_W    = 3;
    localparam logic        REG_LIMIT     = 1'b0;
    localparam logic [7:0]  LIMIT_RESET   = 8'd128;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  bank;
        logic [15:0] row;
        logic [7:0]  tag;
    } t_cmd;

    typedef struct packed {
        logic        accepted;
        logic        head_valid;
        logic [7:0]  head_tag;
        logic [15:0] head_row;
        logic        further_request;
        logic        further_row_hit;
        logic [3:0]  bank_count;
        logic        has_space;
    } t_result;

endpackage

>>> src/per_bank_request_queues.sv
// ----------------------------------------------------------------------------
// per_bank_request_queues
// Request buffer with one circular queue per bank, entries held in a shared
// tag memory and row memory, pointers and fills in per-bank registers.
// The result beat is registered and comes in the cycle after start is taken,
// from the synchronous memory read of the head and second entries.
// Throughput: one command per cycle while busy is low; counters update at accept,
// and a store into the entry being read is forwarded around the memory.
// Reset: synchronous; clears fills, head pointers and total, limit to 128;
// busy is high during reset and the cycle after. Results cannot be stalled.
// ----------------------------------------------------------------------------
module per_bank_request_queues #(
    parameter int BANKS       = pbrq_pkg::BANKS_DEF,
    parameter int QUEUE_DEPTH = pbrq_pkg::QUEUE_DEPTH_DEF,
    parameter int ROW_BITS    = pbrq_pkg::ROW_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  pbrq_pkg::t_cmd                i_cmd,
    output logic                          o_done,
    output pbrq_pkg::t_result             o_result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbrq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SLOTS  = BANKS * QUEUE_DEPTH;
    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int OFF_W  = PTR_W + 2;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TOT_W  = $clog2(SLOTS + 1);
    localparam int RW     = (ROW_BITS < 16) ? ROW_BITS : 16;

    // ---- configuration ----
    logic [7:0] r_limit;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == pbrq_pkg::REG_LIMIT) ? {24'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= pbrq_pkg::LIMIT_RESET;
        end else if (cfg_wr && paddr[2] == pbrq_pkg::REG_LIMIT) begin
            r_limit <= pwdata[7:0];
        end
    end

    // ---- per-bank state ----
    logic [CNT_W-1:0] r_count [BANKS];
    logic [PTR_W-1:0] r_head  [BANKS];
    logic [TOT_W-1:0] r_total;
    logic             r_busy;

    // ---- entry memories ----
    logic [7:0]    tag_mem [SLOTS];
    logic [RW-1:0] row_mem [SLOTS];

    function automatic logic [OFF_W-1:0] wrap(input logic [OFF_W-1:0] x);
        logic [OFF_W-1:0] d;
        d = OFF_W'(QUEUE_DEPTH);
        return (x >= d) ? x - d : x;
    endfunction

    logic              accept;
    logic              bank_ok;
    logic [BANK_W-1:0] bidx;
    logic [CNT_W-1:0]  cnt;
    logic [PTR_W-1:0]  head;
    logic              do_store;
    logic              do_remove;
    logic [CNT_W-1:0]  n_count;
    logic [PTR_W-1:0]  n_head;
    logic [TOT_W-1:0]  n_total;
    logic [OFF_W-1:0]  tail_off;
    logic [OFF_W-1:0]  sec_off;
    logic [SLOT_W-1:0] base_slot;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] sec_slot;
    logic [RW-1:0]     in_row;

    assign busy    = r_busy;
    assign accept  = start && !r_busy;
    assign bank_ok = 32'(i_cmd.bank) < BANKS;
    // out-of-range banks steer to bank 0 but change nothing
    assign bidx    = bank_ok ? BANK_W'(i_cmd.bank) : '0;
    assign cnt     = r_count[bidx];
    assign head    = r_head[bidx];
    assign in_row  = i_cmd.row[RW-1:0];

    always_comb begin
        do_store  = bank_ok && i_cmd.action == pbrq_pkg::ACT_STORE
                    && 32'(cnt) < QUEUE_DEPTH && 32'(r_total) < 32'(r_limit);
        do_remove = bank_ok && i_cmd.action == pbrq_pkg::ACT_REMOVE && cnt != '0;
        n_count   = cnt;
        n_head    = head;
        n_total   = r_total;
        if (do_store) begin
            n_count = cnt + 1'b1;
            n_total = r_total + 1'b1;
        end else if (do_remove) begin
            n_count = cnt - 1'b1;
            n_total = r_total - 1'b1;
            n_head  = PTR_W'(wrap(OFF_W'(head) + OFF_W'(1)));
        end
        tail_off  = wrap(OFF_W'(head) + OFF_W'(cnt));
        sec_off   = wrap(OFF_W'(n_head) + OFF_W'(1));
        base_slot = SLOT_W'(SLOT_W'(bidx) * SLOT_W'(QUEUE_DEPTH));
        tail_slot = base_slot + SLOT_W'(tail_off);
        head_slot = base_slot + SLOT_W'(n_head);
        sec_slot  = base_slot + SLOT_W'(sec_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BANKS; b++) begin
                r_count[b] <= '0;
                r_head[b]  <= '0;
            end
            r_total <= '0;
            r_busy  <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (accept && bank_ok) begin
                r_count[bidx] <= n_count;
                r_head[bidx]  <= n_head;
                r_total       <= n_total;
            end
        end
    end

    // read-first memories, write at tail, read head and second entry
    logic [7:0]    r_tag_head;
    logic [RW-1:0] r_row_head;
    logic [RW-1:0] r_row_sec;

    always_ff @(posedge i_clk) begin
        if (accept && do_store) begin
            tag_mem[tail_slot] <= i_cmd.tag;
            row_mem[tail_slot] <= in_row;
        end
        if (accept) begin
            r_tag_head <= tag_mem[head_slot];
            r_row_head <= row_mem[head_slot];
            r_row_sec  <= row_mem[sec_slot];
        end
    end

    // ---- result beat ----
    logic             r_done;
    logic             r_accepted;
    logic             r_hv;
    logic             r_fr;
    logic [3:0]       r_cnt;
    logic             r_space;
    logic [RW-1:0]    r_row;
    logic [7:0]       r_wtag;
    logic             r_fwd_head;
    logic             r_fwd_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= accept;
        end
        if (accept) begin
            r_accepted <= bank_ok && (do_store || do_remove
                          || (i_cmd.action != pbrq_pkg::ACT_STORE
                              && i_cmd.action != pbrq_pkg::ACT_REMOVE));
            r_hv       <= bank_ok && n_count != '0;
            r_fr       <= bank_ok && 32'(n_count) >= 2;
            r_cnt      <= bank_ok ? 4'(n_count) : 4'd0;
            r_space    <= 32'(n_total) < 32'(r_limit);
            r_row      <= in_row;
            r_wtag     <= i_cmd.tag;
            // entry written this cycle is the one being read
            r_fwd_head <= do_store && tail_slot == head_slot;
            r_fwd_sec  <= do_store && tail_slot == sec_slot;
        end
    end

    logic [7:0]    head_tag;
    logic [RW-1:0] head_row;
    logic [RW-1:0] sec_row;

    assign head_tag = r_fwd_head ? r_wtag : r_tag_head;
    assign head_row = r_fwd_head ? r_row  : r_row_head;
    assign sec_row  = r_fwd_sec  ? r_row  : r_row_sec;

    always_comb begin
        o_result                 = '0;
        o_result.accepted        = r_accepted;
        o_result.head_valid      = r_hv;
        o_result.head_tag        = r_hv ? head_tag : 8'd0;
        o_result.head_row        = r_hv ? 16'(head_row) : 16'd0;
        o_result.further_request = r_fr;
        o_result.further_row_hit = r_fr && sec_row == r_row;
        o_result.bank_count      = r_cnt;
        o_result.has_space       = r_space;
    end

    assign o_done = r_done;

endmodule
